>>> rtl/rgb_to_hsl_pixel_assert.svh
// assertion macros for the rgb to hsl pixel converter
// included by rgb_to_hsl_pixel.sv; no other dependencies
`ifndef RGB_TO_HSL_PIXEL_ASSERT_SVH
`define RGB_TO_HSL_PIXEL_ASSERT_SVH
`ifndef SYNTHESIS
`define RTH_ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("rgb_to_hsl_pixel: check failed");
`define RTH_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgb_to_hsl_pixel: check failed");
`else
`define RTH_ASSERT_ALWAYS(lbl, clk, rst, prop)
`define RTH_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/rgbhsl_pkg.sv
// widths and constants for the rgb to hsl pixel converter
// no dependencies
`timescale 1ns / 1ps
package rgbhsl_pkg;
   localparam int ChanW   = 8;                    // colour channel width
   localparam int QuotW   = 8;                    // quotient bits of both dividers
   localparam int HueNumW = 11;                   // numerator and 6*chroma, below 1536
   localparam int HueRemW = HueNumW + 8;          // 255 * numerator
   localparam int SatRemW = 2 * ChanW;            // 255 * chroma
   localparam int DivStages = QuotW;              // one quotient bit per stage
   localparam int ReqW = 3 * ChanW;
   localparam int RspW = 3 * ChanW;

   typedef logic [ChanW-1:0]   chan_type;
   typedef logic [HueNumW-1:0] hue_num_type;
   typedef logic [HueRemW-1:0] hue_rem_type;
   typedef logic [SatRemW-1:0] sat_rem_type;
   typedef logic [QuotW-1:0]   quot_type;
endpackage

>>> rtl/rgb_to_hsl_pixel.sv
// rgb to hsl pixel converter: front stage, x255 stage, 8-stage restoring dividers
// depends on rgbhsl_pkg and rgb_to_hsl_pixel_assert.svh
`timescale 1ns / 1ps
// a request passes the front stage, the x255 stage and the divider stages in turn
// throughput: one pixel per cycle while the output is not stalled; each of the 8
//   divider stages resolves one quotient bit of hue and saturation side by side
// stages advance on their own, so bubbles close up while the output is stalled
// reset: synchronous, active high, clears all valid bits; payload is not reset
`include "rgb_to_hsl_pixel_assert.svh"
module rgb_to_hsl_pixel (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [rgbhsl_pkg::ReqW-1:0] req_tdata,  // red, green, blue
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [rgbhsl_pkg::RspW-1:0] rsp_tdata   // hue, saturation, lightness
);
   import rgbhsl_pkg::*;

   localparam int Last = DivStages;

   // front stage registers
   logic        front_v_ff;
   hue_num_type front_num_ff, front_num_in;
   hue_num_type front_c6_ff, front_c6_in;
   chan_type    front_c_ff, front_c_in;
   chan_type    front_den_ff, front_den_in;
   chan_type    front_lig_ff, front_lig_in;
   logic        front_load;

   // scaling stage (index 0) and divider stages (1..Last)
   logic        v_ff    [0:Last];
   hue_rem_type hrem_ff [0:Last];
   hue_num_type hden_ff [0:Last];
   quot_type    hq_ff   [0:Last];
   sat_rem_type srem_ff [0:Last];
   chan_type    sden_ff [0:Last];
   quot_type    sq_ff   [0:Last];
   chan_type    lig_ff  [0:Last];
   logic        load    [0:Last];

   hue_rem_type hrem_in [1:Last];
   quot_type    hq_in   [1:Last];
   sat_rem_type srem_in [1:Last];
   quot_type    sq_in   [1:Last];

   chan_type red, green, blue, mx, mn, chroma;
   logic [ChanW:0] sum;
   logic red_top, green_top;

   assign red   = req_tdata[ChanW-1:0];
   assign green = req_tdata[2*ChanW-1:ChanW];
   assign blue  = req_tdata[3*ChanW-1:2*ChanW];

   // per-stage load enables, from the output back to the input
   always_comb begin
      load[Last] = !v_ff[Last] || rsp_tready;
      for (int k = Last - 1; k >= 0; k--) begin
         load[k] = !v_ff[k] || load[k+1];
      end
      front_load = !front_v_ff || load[0];
   end
   assign req_tready = front_load;

   // front stage: max, min, lightness, sector numerator, 6*chroma and saturation divisor
   always_comb begin
      red_top   = (red >= green) && (red >= blue);
      green_top = !red_top && (green >= blue);
      if (red_top) begin
         mx = red;
      end else if (green_top) begin
         mx = green;
      end else begin
         mx = blue;
      end
      if ((red <= green) && (red <= blue)) begin
         mn = red;
      end else if (green <= blue) begin
         mn = green;
      end else begin
         mn = blue;
      end
      chroma      = mx - mn;
      sum         = {1'b0, mx} + {1'b0, mn};
      front_lig_in = sum[ChanW:1];
      front_c_in   = chroma;
      front_c6_in  = HueNumW'(chroma) * HueNumW'(6);
      if (red_top) begin
         if (green >= blue) begin
            front_num_in = HueNumW'(green - blue);
         end else begin
            front_num_in = front_c6_in - HueNumW'(blue - green);
         end
      end else if (green_top) begin
         front_num_in = (HueNumW'(chroma) << 1) + HueNumW'(blue) - HueNumW'(red);
      end else begin
         front_num_in = (HueNumW'(chroma) << 2) + HueNumW'(red) - HueNumW'(green);
      end
      if (sum < (ChanW+1)'(255)) begin
         front_den_in = sum[ChanW-1:0];
      end else begin
         front_den_in = ChanW'((ChanW+1)'(510) - sum);
      end
      // gray pixel: zero numerators over safe divisors give zero quotients
      if (chroma == '0) begin
         front_num_in = '0;
         front_c6_in  = HueNumW'(6);
         front_den_in = ChanW'(1);
      end
   end

   // divider stages: one restoring step for each quotient
   always_comb begin
      for (int k = 0; k < DivStages; k++) begin
         hue_rem_type hsh;
         sat_rem_type ssh;
         logic        hbit, sbit;
         hsh  = HueRemW'(hden_ff[k]) << (DivStages - 1 - k);
         ssh  = SatRemW'(sden_ff[k]) << (DivStages - 1 - k);
         hbit = hrem_ff[k] >= hsh;
         sbit = srem_ff[k] >= ssh;
         hrem_in[k+1] = hbit ? hrem_ff[k] - hsh : hrem_ff[k];
         srem_in[k+1] = sbit ? srem_ff[k] - ssh : srem_ff[k];
         hq_in[k+1]   = {hq_ff[k][QuotW-2:0], hbit};
         sq_in[k+1]   = {sq_ff[k][QuotW-2:0], sbit};
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         front_v_ff <= 1'b0;
         for (int k = 0; k <= Last; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         if (front_load) begin
            front_v_ff <= req_tvalid;
         end
         if (load[0]) begin
            v_ff[0] <= front_v_ff;
         end
         for (int k = 1; k <= Last; k++) begin
            if (load[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (front_load) begin
         front_num_ff <= front_num_in;
         front_c6_ff  <= front_c6_in;
         front_c_ff   <= front_c_in;
         front_den_ff <= front_den_in;
         front_lig_ff <= front_lig_in;
      end
      // scale by 255 as x*256 - x
      if (load[0]) begin
         hrem_ff[0] <= {front_num_ff, 8'b0} - HueRemW'(front_num_ff);
         srem_ff[0] <= {front_c_ff, 8'b0} - SatRemW'(front_c_ff);
         hden_ff[0] <= front_c6_ff;
         sden_ff[0] <= front_den_ff;
         hq_ff[0]   <= '0;
         sq_ff[0]   <= '0;
         lig_ff[0]  <= front_lig_ff;
      end
      for (int k = 1; k <= Last; k++) begin
         if (load[k]) begin
            hrem_ff[k] <= hrem_in[k];
            srem_ff[k] <= srem_in[k];
            hden_ff[k] <= hden_ff[k-1];
            sden_ff[k] <= sden_ff[k-1];
            hq_ff[k]   <= hq_in[k];
            sq_ff[k]   <= sq_in[k];
            lig_ff[k]  <= lig_ff[k-1];
         end
      end
   end

   assign rsp_tvalid = v_ff[Last];
   assign rsp_tdata  = {lig_ff[Last], sq_ff[Last], hq_ff[Last]};

   // checks
   `RTH_ASSERT_IMPLY(a_div_nonzero, clock, reset, v_ff[0],
      (hden_ff[0] != '0) && (sden_ff[0] != '0))
   `RTH_ASSERT_IMPLY(a_rem_below_den, clock, reset, v_ff[Last],
      (hrem_ff[Last] < HueRemW'(hden_ff[Last])) && (srem_ff[Last] < SatRemW'(sden_ff[Last])))
   `RTH_ASSERT_IMPLY(a_hue_range, clock, reset, rsp_tvalid, hq_ff[Last] != '1)
   `RTH_ASSERT_IMPLY(a_ready_when_out_empty, clock, reset, !v_ff[Last], req_tready)
endmodule

>>> sim/tb_top.sv
// self-checking bench for rgb_to_hsl_pixel: random and directed pixels, hsl predicted per request
// depends on rgbhsl_pkg and rgb_to_hsl_pixel
`timescale 1ns / 1ps
module tb_top;
   import rgbhsl_pkg::*;

   localparam int NumRandom = 1800;
   localparam int WatchdogCycles = 100000;
   localparam int DrainCycles = 30;

   typedef struct {
      chan_type red;
      chan_type green;
      chan_type blue;
   } pixel_type;

   typedef struct {
      chan_type hue;
      chan_type saturation;
      chan_type lightness;
   } hsl_type;

   logic            clock;
   logic            reset = 1'b1;
   logic            req_tvalid = 1'b0;
   logic            req_tready;
   logic [ReqW-1:0] req_tdata = '0;   // red, green, blue
   logic            rsp_tvalid;
   logic            rsp_tready = 1'b0;
   logic [RspW-1:0] rsp_tdata;        // hue, saturation, lightness

   pixel_type pixel_queue[$];
   hsl_type   hsl_expected[$];
   pixel_type in_flight;
   int        issued = 0;
   int        num_directed = 0;
   int        phase_start[3];
   int        phase;
   int        errors = 0;

   rgb_to_hsl_pixel dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // predicted hsl of one pixel, exact integer arithmetic
   function automatic hsl_type rgb_to_hsl(pixel_type px);
      hsl_type     res;
      chan_type    mx;
      chan_type    mn;
      logic [7:0]  chroma;
      logic [8:0]  sum;
      logic [10:0] num;
      logic [18:0] hue_full;
      logic [15:0] sat_full;
      mx = px.red;
      if (px.green > mx) mx = px.green;
      if (px.blue > mx) mx = px.blue;
      mn = px.red;
      if (px.green < mn) mn = px.green;
      if (px.blue < mn) mn = px.blue;
      chroma = mx - mn;
      sum = {1'b0, mx} + {1'b0, mn};
      res.lightness = sum[8:1];
      res.hue = '0;
      res.saturation = '0;
      if (chroma != 0) begin
         // sector from the largest channel, ties go red, green, blue
         if (mx == px.red) begin
            if (px.green >= px.blue) num = 11'(px.green) - 11'(px.blue);
            else num = 11'd6 * 11'(chroma) - (11'(px.blue) - 11'(px.green));
         end else if (mx == px.green) begin
            num = 11'd2 * 11'(chroma) + 11'(px.blue) - 11'(px.red);
         end else begin
            num = 11'd4 * 11'(chroma) + 11'(px.red) - 11'(px.green);
         end
         hue_full = (19'd255 * 19'(num)) / (19'd6 * 19'(chroma));
         res.hue = hue_full[7:0];
         if (sum < 9'd255) sat_full = (16'd255 * 16'(chroma)) / 16'(sum);
         else sat_full = (16'd255 * 16'(chroma)) / (16'd510 - 16'(sum));
         res.saturation = sat_full[7:0];
      end
      return res;
   endfunction

   function automatic chan_type pick_extreme();
      case ($urandom_range(0, 6))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd127;
         3: return 8'd128;
         4: return 8'd254;
         5: return 8'd255;
         default: return chan_type'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic add_pixel(input int r, input int g, input int b);
      pixel_type px;
      px.red = chan_type'(r);
      px.green = chan_type'(g);
      px.blue = chan_type'(b);
      pixel_queue.insert(pixel_queue.size(), px);
   endtask

   // stimulus: directed corners first, then a random mix
   initial begin
      int        sel;
      chan_type  v;
      chan_type  w;
      // black, white and grays
      add_pixel(0, 0, 0);
      add_pixel(255, 255, 255);
      add_pixel(128, 128, 128);
      add_pixel(1, 1, 1);
      add_pixel(254, 254, 254);
      // primaries and sector ties
      add_pixel(255, 0, 0);
      add_pixel(0, 255, 0);
      add_pixel(0, 0, 255);
      add_pixel(255, 255, 0);
      add_pixel(0, 255, 255);
      add_pixel(255, 0, 255);
      // red sector wrapping to the top of the hue range
      add_pixel(255, 0, 1);
      add_pixel(200, 10, 90);
      // tiny and large chroma, sum below, at and above 255
      add_pixel(1, 0, 0);
      add_pixel(0, 1, 0);
      add_pixel(0, 0, 1);
      add_pixel(254, 0, 0);
      add_pixel(127, 0, 0);
      add_pixel(128, 127, 127);
      add_pixel(127, 127, 128);
      add_pixel(255, 254, 254);
      // general colours in each sector
      add_pixel(200, 100, 50);
      add_pixel(50, 200, 100);
      add_pixel(100, 50, 200);
      num_directed = pixel_queue.size();

      for (int i = 0; i < NumRandom; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 60) begin
            add_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
         end else if (sel < 70) begin
            v = chan_type'($urandom_range(0, 255));
            add_pixel(v, v, v);
         end else if (sel < 85) begin
            // two channels tied, to exercise the sector priority
            v = chan_type'($urandom_range(0, 255));
            w = chan_type'($urandom_range(0, 255));
            case ($urandom_range(0, 2))
               0: add_pixel(v, v, w);
               1: add_pixel(w, v, v);
               default: add_pixel(v, w, v);
            endcase
         end else begin
            add_pixel(pick_extreme(), pick_extreme(), pick_extreme());
         end
      end
      phase_start[0] = 0;
      phase_start[1] = num_directed + NumRandom / 3;
      phase_start[2] = num_directed + 2 * NumRandom / 3;
   end

   // idle pattern follows how far the stimulus has got
   always_comb begin
      if (issued < phase_start[1]) phase = 0;
      else if (issued < phase_start[2]) phase = 1;
      else phase = 2;
   end

   // request driver
   always @(posedge clock) begin
      logic hold;
      logic idle;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            hsl_expected.insert(hsl_expected.size(), rgb_to_hsl(in_flight));
         end
         if (!req_tvalid || req_tready) begin
            // let the pipe empty at the end of the directed part and at each phase change
            hold = (issued == num_directed || issued == phase_start[1] ||
                    issued == phase_start[2]) && hsl_expected.size() != 0;
            case (phase)
               0: idle = $urandom_range(0, 99) < 37;
               1: idle = $urandom_range(0, 99) < 61;
               default: idle = 1'b0;
            endcase
            if (pixel_queue.size() != 0 && !hold && !idle) begin
               in_flight = pixel_queue.pop_front();
               req_tdata <= {in_flight.blue, in_flight.green, in_flight.red};
               req_tvalid <= 1'b1;
               issued <= issued + 1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         case (phase)
            0: rsp_tready <= $urandom_range(0, 99) >= 61;
            1: rsp_tready <= $urandom_range(0, 99) >= 37;
            default: rsp_tready <= 1'b1;
         endcase
      end
   end

   // result monitor
   always @(posedge clock) begin
      hsl_type got;
      hsl_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.hue = rsp_tdata[7:0];
         got.saturation = rsp_tdata[15:8];
         got.lightness = rsp_tdata[23:16];
         if (hsl_expected.size() == 0) begin
            $error("result with no request outstanding: %h", rsp_tdata);
            errors++;
         end else begin
            want = hsl_expected.pop_front();
            if (got.hue !== want.hue) begin
               $error("hue: expected %0d, got %0d", want.hue, got.hue);
               errors++;
            end
            if (got.saturation !== want.saturation) begin
               $error("saturation: expected %0d, got %0d", want.saturation, got.saturation);
               errors++;
            end
            if (got.lightness !== want.lightness) begin
               $error("lightness: expected %0d, got %0d", want.lightness, got.lightness);
               errors++;
            end
         end
      end
   end

   // end of run, sampled between edges once the driver has settled
   initial begin
      @(negedge reset);
      @(posedge clock);
      while (pixel_queue.size() != 0 || req_tvalid || hsl_expected.size() != 0)
         @(negedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      for (int n = 0; n < WatchdogCycles; n++) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end
endmodule
